[hw/rtl/plist_pkg.sv]
package plist_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int OpW          = 2;
    localparam int PosW         = 8;
    localparam int ValW         = 32;
    localparam int StatusW      = 2;
    localparam int CountW       = 5;

    localparam logic [OpW-1:0] OP_INSERT = 2'd0;
    localparam logic [OpW-1:0] OP_DELETE = 2'd1;
    localparam logic [OpW-1:0] OP_GET    = 2'd2;
    localparam logic [OpW-1:0] OP_UPDATE = 2'd3;

    localparam logic [StatusW-1:0] ST_OK     = 2'd0;
    localparam logic [StatusW-1:0] ST_FULL   = 2'd1;
    localparam logic [StatusW-1:0] ST_EMPTY  = 2'd2;
    localparam logic [StatusW-1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [OpW-1:0]         operation;
        logic [PosW-1:0]        position;
        logic signed [ValW-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [StatusW-1:0]     status;
        logic signed [ValW-1:0] read_value;
        logic [CountW-1:0]      count;
    } t_out_item;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic            ins;
        logic            del;
        logic            upd;
        logic [PosW-1:0] idx;
    } t_cell_cmd;

endpackage

[hw/rtl/plist_cell.sv]
module plist_cell #(
    parameter int IDX = 0
) (
    input  logic                             i_clk,
    input  plist_pkg::t_cell_cmd             i_cmd,
    input  logic signed [plist_pkg::ValW-1:0] i_value,
    input  logic signed [plist_pkg::ValW-1:0] i_lower,
    input  logic signed [plist_pkg::ValW-1:0] i_upper,
    output logic signed [plist_pkg::ValW-1:0] o_entry
);

    localparam logic [plist_pkg::PosW-1:0] MyIdx = plist_pkg::PosW'(IDX);

    logic signed [plist_pkg::ValW-1:0] r_entry;
    logic signed [plist_pkg::ValW-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (MyIdx > i_cmd.idx) begin
                n_entry = i_lower;
            end else if (MyIdx == i_cmd.idx) begin
                n_entry = i_value;
            end
        end else if (i_cmd.del) begin
            // close the gap: take the neighbor above
            if (MyIdx >= i_cmd.idx) begin
                n_entry = i_upper;
            end
        end else if (i_cmd.upd && (MyIdx == i_cmd.idx)) begin
            n_entry = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

[hw/rtl/positional_list_engine_top.sv]
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_ready    i_in  (operation, position, value)
// result    out        o_out_valid / i_out_ready  o_out (status, read_value, count)
//
// one item per cycle: the row of entry cells and the output register are both
// written at the edge that accepts an item, so its result is valid the next cycle.
// a new item is taken while the output register is empty or being drained.
// synchronous active-low reset empties the list and the output register;
// entry cells are not reset and are only read after being written.
module positional_list_engine_top #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  plist_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output plist_pkg::t_out_item o_out
);

    localparam int FillW = $clog2(CAPACITY + 1);
    localparam int CmpW  = plist_pkg::PosW + 1;

    logic [FillW-1:0]     r_fill;
    logic [FillW-1:0]     n_fill;
    logic                 r_out_valid;
    plist_pkg::t_out_item r_out;
    plist_pkg::t_out_item n_out;

    logic                 accept;
    logic [CmpW-1:0]      pos_c;
    logic [CmpW-1:0]      fill_c;
    logic                 is_ins;
    logic                 ok;
    logic                 rd_en;
    logic [plist_pkg::StatusW-1:0] status;
    plist_pkg::t_cell_cmd cmd;
    logic signed [plist_pkg::ValW-1:0] rd_val;

    logic signed [plist_pkg::ValW-1:0] w_entry [CAPACITY];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign pos_c  = CmpW'(i_in.position);
    assign fill_c = CmpW'(r_fill);
    assign is_ins = (i_in.operation == plist_pkg::OP_INSERT);

    always_comb begin
        status = plist_pkg::ST_OK;
        if (is_ins) begin
            if (r_fill == FillW'(CAPACITY)) begin
                status = plist_pkg::ST_FULL;
            end else if ((pos_c == '0) || (pos_c > fill_c + CmpW'(1))) begin
                status = plist_pkg::ST_BADPOS;
            end
        end else begin
            if (r_fill == '0) begin
                status = plist_pkg::ST_EMPTY;
            end else if ((pos_c == '0) || (pos_c > fill_c)) begin
                status = plist_pkg::ST_BADPOS;
            end
        end
    end

    assign ok    = (status == plist_pkg::ST_OK);
    assign rd_en = ok && ((i_in.operation == plist_pkg::OP_DELETE)
                       || (i_in.operation == plist_pkg::OP_GET));

    always_comb begin
        cmd.ins = accept && ok && is_ins;
        cmd.del = accept && ok && (i_in.operation == plist_pkg::OP_DELETE);
        cmd.upd = accept && ok && (i_in.operation == plist_pkg::OP_UPDATE);
        cmd.idx = i_in.position - plist_pkg::PosW'(1);
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [plist_pkg::ValW-1:0] lower;
        logic signed [plist_pkg::ValW-1:0] upper;
        if (k == 0) begin : g_first
            assign lower = i_in.value;
        end else begin : g_mid
            assign lower = w_entry[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign upper = w_entry[k];
        end else begin : g_inner
            assign upper = w_entry[k+1];
        end
        plist_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_value (i_in.value),
            .i_lower (lower),
            .i_upper (upper),
            .o_entry (w_entry[k])
        );
    end

    // one-hot select of the addressed cell
    always_comb begin
        rd_val = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (cmd.idx == plist_pkg::PosW'(k)) begin
                rd_val = rd_val | w_entry[k];
            end
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (cmd.ins) begin
            n_fill = r_fill + FillW'(1);
        end else if (cmd.del) begin
            n_fill = r_fill - FillW'(1);
        end
    end

    always_comb begin
        n_out.status     = status;
        n_out.read_value = rd_en ? rd_val : '0;
        n_out.count      = plist_pkg::CountW'(n_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[verif/tb_positional_list_engine_top.sv]
module tb_positional_list_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP        = plist_pkg::CAPACITY_DEF;
    localparam int CYCLE_CAP  = 300000;
    localparam int RAND_ITEMS = 540;
    localparam int MODEL      = 0;
    localparam int PLAN       = 1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    plist_pkg::t_in_item  in_item   = '0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    plist_pkg::t_out_item out_item;

    plist_pkg::t_in_item  pending_reqs [$];
    plist_pkg::t_out_item expected_rsps [$];
    // two list images: the model checks results, the plan steers stimulus
    logic signed [plist_pkg::ValW-1:0] img_slot [2][CAP];
    int                   img_fill [2];
    int                   send_idle_pct = 15;
    int                   recv_idle_pct = 81;
    int                   mismatches    = 0;
    int                   cycles        = 0;

    positional_list_engine_top #(
        .CAPACITY(CAP)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // applies one request to a list image and returns the result it yields
    function automatic plist_pkg::t_out_item list_apply(input int img,
                                                        input plist_pkg::t_in_item req);
        plist_pkg::t_out_item res;
        int                   p;
        int                   k;
        res.status     = plist_pkg::ST_OK;
        res.read_value = '0;
        p = int'(req.position);
        if (req.operation == plist_pkg::OP_INSERT) begin
            if (img_fill[img] >= CAP) begin
                res.status = plist_pkg::ST_FULL;
            end else if (p < 1 || p > img_fill[img] + 1) begin
                res.status = plist_pkg::ST_BADPOS;
            end else begin
                for (k = img_fill[img]; k > p - 1; k--)
                    img_slot[img][k] = img_slot[img][k-1];
                img_slot[img][p-1] = req.value;
                img_fill[img]++;
            end
        end else if (img_fill[img] == 0) begin
            res.status = plist_pkg::ST_EMPTY;
        end else if (p < 1 || p > img_fill[img]) begin
            res.status = plist_pkg::ST_BADPOS;
        end else begin
            case (req.operation)
                plist_pkg::OP_DELETE: begin
                    res.read_value = img_slot[img][p-1];
                    for (k = p - 1; k + 1 < img_fill[img]; k++)
                        img_slot[img][k] = img_slot[img][k+1];
                    img_fill[img]--;
                end
                plist_pkg::OP_GET: begin
                    res.read_value = img_slot[img][p-1];
                end
                plist_pkg::OP_UPDATE: begin
                    img_slot[img][p-1] = req.value;
                end
                default: begin
                end
            endcase
        end
        res.count = plist_pkg::CountW'(img_fill[img]);
        return res;
    endfunction

    // the plan image tracks the fill the queued requests will leave behind
    task automatic push_req(input logic [plist_pkg::OpW-1:0] op, input int pos,
                            input logic [plist_pkg::ValW-1:0] val);
        plist_pkg::t_in_item req;
        req.operation = op;
        req.position  = plist_pkg::PosW'(pos);
        req.value     = val;
        void'(list_apply(PLAN, req));
        pending_reqs.push_back(req);
    endtask

    function automatic logic [plist_pkg::ValW-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // fill level wanders toward a moving target so empty and full both get hit
    task automatic queue_random_reqs(input int n);
        int                        f;
        int                        target;
        int                        lim;
        int                        pos;
        logic [plist_pkg::OpW-1:0] op;
        target = CAP;
        for (int i = 0; i < n; i++) begin
            f = img_fill[PLAN];
            if (f == target && $urandom_range(3) == 0) begin
                case ($urandom_range(3))
                    0: target = 0;
                    1: target = CAP;
                    default: target = $urandom_range(CAP);
                endcase
            end
            if ($urandom_range(99) < 8) begin
                op  = plist_pkg::OpW'($urandom_range(3));
                pos = $urandom_range(255);
            end else begin
                if (f < target)
                    op = ($urandom_range(9) < 7) ? plist_pkg::OP_INSERT
                                                 : plist_pkg::OpW'($urandom_range(3, 1));
                else if (f > target)
                    op = ($urandom_range(9) < 7) ? plist_pkg::OP_DELETE
                                                 : plist_pkg::OpW'($urandom_range(3));
                else
                    op = plist_pkg::OpW'($urandom_range(3));
                lim = (op == plist_pkg::OP_INSERT) ? f + 1 : f;
                if ($urandom_range(15) == 0)
                    pos = ($urandom_range(1) == 1) ? 0 : lim + 1;
                else
                    pos = (lim == 0) ? 1 : $urandom_range(lim, 1);
            end
            push_req(op, pos, pick_value());
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0);
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_item  <= pending_reqs.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor: predicts on each accepted request, checks each accepted result
    always @(posedge clk) begin
        plist_pkg::t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                expected_rsps.push_back(list_apply(MODEL, in_item));
            if (out_valid && out_ready) begin
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: status %0d read_value %0d count %0d",
                                 out_item.status, out_item.read_value, out_item.count);
                end else begin
                    want = expected_rsps.pop_front();
                    if (out_item.status !== want.status ||
                        out_item.read_value !== want.read_value ||
                        out_item.count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("cycle %0d exp/act status %0d/%0d value %0d/%0d count %0d/%0d",
                                     cycles, want.status, out_item.status,
                                     want.read_value, out_item.read_value,
                                     want.count, out_item.count);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        img_fill[MODEL] = 0;
        img_fill[PLAN]  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty list, bad insert positions, then fill to capacity
        push_req(plist_pkg::OP_DELETE, 1, 32'h0);
        push_req(plist_pkg::OP_GET, 1, 32'h0);
        push_req(plist_pkg::OP_UPDATE, 0, 32'h1234_5678);
        push_req(plist_pkg::OP_INSERT, 0, 32'h5);
        push_req(plist_pkg::OP_INSERT, 2, 32'h6);
        for (int k = 0; k < CAP; k++) begin
            case (k % 3)
                0: push_req(plist_pkg::OP_INSERT, 1,
                            (k == 0) ? 32'h8000_0000 : pick_value());
                1: push_req(plist_pkg::OP_INSERT, img_fill[PLAN] + 1,
                            (k == 1) ? 32'h7fff_ffff : pick_value());
                default: push_req(plist_pkg::OP_INSERT, img_fill[PLAN] / 2 + 1,
                                  (k == 2) ? 32'hffff_ffff : pick_value());
            endcase
        end
        // full is reported ahead of a bad position
        push_req(plist_pkg::OP_INSERT, 0, 32'h7);
        push_req(plist_pkg::OP_INSERT, 255, 32'h8);
        push_req(plist_pkg::OP_GET, CAP + 1, 32'h0);
        push_req(plist_pkg::OP_GET, 0, 32'h0);
        push_req(plist_pkg::OP_UPDATE, CAP, 32'h5a5a_5a5a);
        push_req(plist_pkg::OP_DELETE, CAP, 32'h0);
        push_req(plist_pkg::OP_DELETE, 1, 32'h0);
        push_req(plist_pkg::OP_GET, 1, 32'hffff_0000);

        queue_random_reqs(RAND_ITEMS);
        wait_drained();
        send_idle_pct = 81;
        recv_idle_pct = 15;
        queue_random_reqs(RAND_ITEMS);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_reqs(RAND_ITEMS);
        wait_drained();
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
hw/rtl/plist_pkg.sv
hw/rtl/plist_cell.sv
hw/rtl/positional_list_engine_top.sv
verif/tb_positional_list_engine_top.sv
